// ===== design/u8d_pkg.sv =====
`default_nettype none

package u8d_pkg;

   // Field widths of the byte and result channels and of the pending-sequence state.
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned CODE_POINT_W = 21;
   localparam int unsigned PARTIAL_W    = 15;
   localparam int unsigned OWED_W       = 2;
   localparam int unsigned REQ_DATA_W   = 8;
   localparam int unsigned RSP_DATA_W   = 24;

   // Replacement character, the largest scalar value and the surrogate range.
   localparam logic [CODE_POINT_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [CODE_POINT_W-1:0] MAX_SCALAR_CP  = 21'h10FFFF;
   localparam logic [CODE_POINT_W-1:0] SURROGATE_LO   = 21'h00D800;
   localparam logic [CODE_POINT_W-1:0] SURROGATE_HI   = 21'h00DFFF;

   // Lead byte class boundaries.
   localparam logic [BYTE_W-1:0] ASCII_END     = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD_TWO_MIN  = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD_THREE    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_FOUR     = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD_PAST_MAX = 8'hF5;
   localparam logic [BYTE_W-1:0] LEAD_SURR     = 8'hED;
   localparam logic [BYTE_W-1:0] LEAD_TOP      = 8'hF4;

   // Continuation byte ranges, the plain one and the narrowed ones.
   localparam logic [BYTE_W-1:0] CONT_LOW      = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_HIGH     = 8'hBF;
   localparam logic [BYTE_W-1:0] CONT_LOW_E0   = 8'hA0;
   localparam logic [BYTE_W-1:0] CONT_HIGH_ED  = 8'h9F;
   localparam logic [BYTE_W-1:0] CONT_LOW_F0   = 8'h90;
   localparam logic [BYTE_W-1:0] CONT_HIGH_F4  = 8'h8F;

   // Number of results in a pair.
   localparam logic [1:0] PAIR_NONE = 2'd0;
   localparam logic [1:0] PAIR_ONE  = 2'd1;
   localparam logic [1:0] PAIR_TWO  = 2'd2;

   // One decoded result.
   typedef struct packed {
      logic [CODE_POINT_W-1:0] code_point;
      logic                    replaced;
   } u8d_result_type;

   // The results caused by one byte; last_res is always the final one.
   typedef struct packed {
      logic [1:0]     count;
      u8d_result_type first_res;
      u8d_result_type last_res;
   } u8d_pair_type;

endpackage

`default_nettype wire

// ===== design/u8d_decode.sv =====
`default_nettype none

module u8d_decode
   import u8d_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [BYTE_W-1:0] text_byte,
   input  wire logic              end_of_text,
   output u8d_pair_type           pair
);

   // Pending sequence state.
   logic [OWED_W-1:0]    owed_ff,    owed_in;
   logic [PARTIAL_W-1:0] partial_ff, partial_in;
   logic [BYTE_W-1:0]    low_ff,     low_in;
   logic [BYTE_W-1:0]    high_ff,    high_in;

   logic                    pending;
   logic                    in_range;
   logic [CODE_POINT_W-1:0] joined;
   logic                    broken;
   logic                    lead_emit;
   logic                    lead_started;
   u8d_result_type          lead_res;
   u8d_result_type          repl_res;

   assign pending  = (owed_ff != '0);
   assign in_range = (text_byte >= low_ff) && (text_byte <= high_ff);
   assign joined   = {partial_ff, text_byte[5:0]};
   assign repl_res = '{code_point: REPLACEMENT_CP, replaced: 1'b1};

   // Next state and the results of the byte at the input register.
   always_comb begin
      owed_in      = owed_ff;
      partial_in   = partial_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      broken       = 1'b0;
      lead_emit    = 1'b0;
      lead_started = 1'b0;
      lead_res     = repl_res;
      pair         = '{count: PAIR_NONE, first_res: repl_res, last_res: repl_res};

      if (pending && in_range) begin
         // Continuation byte inside the allowed range.
         owed_in    = owed_ff - OWED_W'(1);
         partial_in = joined[PARTIAL_W-1:0];
         low_in     = CONT_LOW;
         high_in    = CONT_HIGH;
         if (owed_ff == OWED_W'(1)) begin
            pair.count    = PAIR_ONE;
            pair.last_res = '{code_point: joined, replaced: 1'b0};
            partial_in    = '0;
         end else if (end_of_text) begin
            pair.count    = PAIR_ONE;
            owed_in       = '0;
            partial_in    = '0;
         end
      end else begin
         // A pending sequence, if any, is cut short; the byte starts over as a lead.
         broken     = pending;
         owed_in    = '0;
         partial_in = '0;
         low_in     = CONT_LOW;
         high_in    = CONT_HIGH;
         if (text_byte < ASCII_END) begin
            lead_emit = 1'b1;
            lead_res  = '{code_point: CODE_POINT_W'(text_byte), replaced: 1'b0};
         end else if (text_byte < LEAD_TWO_MIN) begin
            lead_emit = 1'b1;
         end else if (text_byte < LEAD_THREE) begin
            lead_started = 1'b1;
            owed_in      = OWED_W'(1);
            partial_in   = PARTIAL_W'(text_byte[4:0]);
         end else if (text_byte < LEAD_FOUR) begin
            lead_started = 1'b1;
            owed_in      = OWED_W'(2);
            partial_in   = PARTIAL_W'(text_byte[3:0]);
            low_in       = (text_byte == LEAD_THREE) ? CONT_LOW_E0 : CONT_LOW;
            high_in      = (text_byte == LEAD_SURR) ? CONT_HIGH_ED : CONT_HIGH;
         end else if (text_byte < LEAD_PAST_MAX) begin
            lead_started = 1'b1;
            owed_in      = OWED_W'(3);
            partial_in   = PARTIAL_W'(text_byte[2:0]);
            low_in       = (text_byte == LEAD_FOUR) ? CONT_LOW_F0 : CONT_LOW;
            high_in      = (text_byte == LEAD_TOP) ? CONT_HIGH_F4 : CONT_HIGH;
         end else begin
            lead_emit = 1'b1;
         end

         // A lead that is also the last byte of the text is a cut subpart.
         if (lead_started && end_of_text) begin
            lead_emit  = 1'b1;
            owed_in    = '0;
            partial_in = '0;
            low_in     = CONT_LOW;
            high_in    = CONT_HIGH;
         end

         // Put the final result in the last slot.
         if (broken && lead_emit) begin
            pair.count    = PAIR_TWO;
            pair.last_res = lead_res;
         end else if (broken) begin
            pair.count    = PAIR_ONE;
         end else if (lead_emit) begin
            pair.count    = PAIR_ONE;
            pair.last_res = lead_res;
         end
      end
   end

   // State advances when the byte moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff    <= '0;
         partial_ff <= '0;
         low_ff     <= CONT_LOW;
         high_ff    <= CONT_HIGH;
      end else if (advance) begin
         owed_ff    <= owed_in;
         partial_ff <= partial_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/u8d_out_buf.sv =====
`default_nettype none

module u8d_out_buf
   import u8d_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire u8d_pair_type            pair,
   input  wire logic                    take,
   output logic                         free,
   output logic                         out_valid,
   output logic [CODE_POINT_W-1:0]      out_code_point,
   output logic                         out_replaced,
   output logic                         out_last
);

   logic [1:0]     count_ff, count_in;
   u8d_result_type first_ff, last_ff;

   // Room for a new pair when empty or once the final held result leaves this cycle.
   assign free = (count_ff == PAIR_NONE) || ((count_ff == PAIR_ONE) && take);

   // Count of results still to deliver.
   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = pair.count;
      end else if (take && (count_ff != PAIR_NONE)) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= PAIR_NONE;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         first_ff <= pair.first_res;
         last_ff  <= pair.last_res;
      end
   end

   // The first slot is shown only while both results remain.
   assign out_valid      = (count_ff != PAIR_NONE);
   assign out_last       = (count_ff == PAIR_ONE);
   assign out_code_point = out_last ? last_ff.code_point : first_ff.code_point;
   assign out_replaced   = out_last ? last_ff.replaced : first_ff.replaced;

endmodule

`default_nettype wire

// ===== design/utf8_strict_decoder_core.sv =====
// Streaming strict UTF-8 decoder.
// The req_ channel takes one text byte per transfer in req_tdata, with
// req_tlast high on the last byte of a text. The rsp_ channel gives decoded
// code points in rsp_tdata; rsp_tuser is high when the result is U+FFFD
// standing in for an ill-formed subpart, and rsp_tlast marks the final result
// caused by one input byte. A byte gives zero, one or two results.
// A byte is held in the input register, is decoded into the result register,
// and is offered on rsp_ from the result register.
// Throughput is one byte per cycle while the receiver accepts and each
// byte gives at most one result; a two-result byte stays until both leave.
// The pending-sequence state is updated as a byte moves into the result
// register, so the next byte sees it at once.
// Reset clears the pending sequence and empties both registers.
// When the receiver stalls, the result stays on rsp_ and one more byte is
// held in the input register; req_tready then drops until results move on.
`default_nettype none

module utf8_strict_decoder_core
   import u8d_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] text_byte
   input  wire logic                  req_tlast,  // end_of_text
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [20:0] code_point, zero above
   output logic                       rsp_tuser,  // [0] replaced
   output logic                       rsp_tlast   // out_last
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eot_ff;
   logic              advance;
   logic              buf_free;
   u8d_pair_type      pair;
   logic [CODE_POINT_W-1:0] out_code_point;

   // Input register: moves on when the result register has room.
   assign advance     = in_valid_ff && buf_free;
   assign req_tready  = !in_valid_ff || buf_free;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[BYTE_W-1:0];
         in_eot_ff  <= req_tlast;
      end
   end

   // Per-byte decode and sequence state.
   u8d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .pair        (pair)
   );

   // Result register with room for two results.
   u8d_out_buf u_out_buf (
      .clock          (clock),
      .reset          (reset),
      .load           (advance),
      .pair           (pair),
      .take           (rsp_tready),
      .free           (buf_free),
      .out_valid      (rsp_tvalid),
      .out_code_point (out_code_point),
      .out_replaced   (rsp_tuser),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W - CODE_POINT_W){1'b0}}, out_code_point};

   // The earlier result of a pair is always a replacement.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser)
      else $error("first of two results is not a replacement");

   // A decoded scalar is never a surrogate and never past the top of the range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (out_code_point <= MAX_SCALAR_CP) &&
         !((out_code_point >= SURROGATE_LO) && (out_code_point <= SURROGATE_HI)))
      else $error("decoded code point is not a scalar value");

   // After the first result of a pair leaves, the final one follows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second result of a pair missing");

endmodule

`default_nettype wire
